// ===== hw/rtl/afc_pkg.sv =====
package afc_pkg;

    localparam int Rounds = 64;
    localparam int NumKeys = 2 * Rounds;
    localparam int RoundW = $clog2(Rounds);
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 64;

    localparam logic [63:0] SEED0 = 64'hc930a011903b456e;
    localparam logic [63:0] SEED1 = 64'hbf7eb1f5d119a477;
    localparam logic [63:0] SEED2 = 64'hfd0c814081b3fcfd;
    localparam logic [63:0] SEED3 = 64'h853064b0a89aecbd;

    typedef enum logic [CfgIdxW-1:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_KEYLEN = 3'd4,
        REG_IV_HI  = 3'd5,
        REG_IV_LO  = 3'd6,
        REG_SPARE  = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_WHITE,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } blk_t;

    function automatic logic [63:0] rol64(input logic [63:0] a, input int n);
        rol64 = (a << n) | (a >> (64 - n));
    endfunction

    function automatic logic [63:0] mix_f(input logic [63:0] x);
        logic [7:0] b [8];
        logic [7:0] o [8];
        for (int i = 0; i < 8; i++) begin
            b[i] = x[63 - 8 * i -: 8];
        end
        o[0] = b[0] + b[2];
        o[1] = b[1] + b[3];
        o[2] = b[2] + b[4];
        o[3] = b[3] + b[5];
        o[4] = b[4] + b[6];
        o[5] = b[5] + b[7];
        o[6] = b[6];
        o[7] = b[7];
        mix_f = {o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7]};
    endfunction

endpackage

// ===== hw/rtl/afc_stream_if.sv =====
interface afc_stream_if #(
    parameter int W = 128
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/afc_keygen.sv =====
// Generator step: one output word per cycle while step is asserted
module afc_keygen (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed,
    input  logic        step,
    input  logic [63:0] key0,
    input  logic [63:0] key1,
    input  logic [63:0] key2,
    input  logic [63:0] key3,
    input  logic [2:0]  key_len,
    output logic [63:0] word
);
    import afc_pkg::*;

    logic [63:0] g_reg [4];
    logic [63:0] g0, g1, g2, g3;
    logic [2:0]  n;

    assign n = (key_len > 3'd4) ? 3'd4 : key_len;

    always_comb
    begin
        g0 = g_reg[0] ^ (rol64(g_reg[3], 1) + g_reg[2]);
        g1 = g_reg[1] + (rol64(g0, 3) ^ g_reg[3]);
        g2 = g_reg[2] ^ rol64(g1 + g0, 6);
        g3 = g_reg[3] + rol64(g2 ^ g1, 11);
        word = g0 ^ g1 ^ g2 ^ g3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) g_reg[i] <= '0;
        end
        else if (seed)
        begin
            g_reg[0] <= SEED0 ^ ((n > 3'd0) ? key0 : 64'd0);
            g_reg[1] <= SEED1 ^ ((n > 3'd1) ? key1 : 64'd0);
            g_reg[2] <= SEED2 ^ ((n > 3'd2) ? key2 : 64'd0);
            g_reg[3] <= SEED3 ^ ((n > 3'd3) ? key3 : 64'd0);
        end
        else if (step)
        begin
            g_reg[0] <= g0;
            g_reg[1] <= g1;
            g_reg[2] <= g2;
            g_reg[3] <= g3;
        end
    end
endmodule

// ===== hw/rtl/afc_round.sv =====
// One cipher round, either direction
module afc_round (
    input  logic        decrypt,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic [63:0] k0,
    input  logic [63:0] k1,
    output logic [63:0] a_out,
    output logic [63:0] b_out
);
    import afc_pkg::*;

    logic [63:0] ea, eb, da, db;

    always_comb
    begin
        ea = rol64(a ^ mix_f(b), 14) + b;
        ea = ea ^ k0;
        eb = rol64(b + ea, 47) ^ k1;
        ea = ea ^ eb;
        eb = eb ^ ea;
        // decrypt: undo swap first
        db = a ^ b;
        da = b ^ db;
        db = rol64(db ^ k1, 17) - da;
        da = rol64((da ^ k0) - db, 50) ^ mix_f(db);
        if (decrypt)
        begin
            a_out = da;
            b_out = db;
        end
        else
        begin
            a_out = eb;
            b_out = ea;
        end
    end
endmodule

// ===== hw/rtl/arx_feistel128_cbc_cipher.sv =====
// channel | dir | payload
// in      | sink   | req_type, restart, block_high, block_low
// out     | source | result_high, result_low
// cfg     | write  | cfg_we, cfg_idx, cfg_data
// With a ready schedule a result beat is offered after the input beat passes
// through load, 64 rounds and done; the next beat is accepted back in idle.
// Expanding the schedule first adds the seed wait, key expansion and whitening.
// The single round unit and key memory port (one key pair per cycle) set the pace.
// Reset clears control and chain; round keys are written before read.
// A stalled result holds in the output register; no new beat until taken.
module arx_feistel128_cbc_cipher (
    input  logic                    clk,
    input  logic                    rst_n,
    afc_stream_if.sink              in_ch,
    afc_stream_if.source            out_ch,
    input  logic                    cfg_we,
    input  logic [afc_pkg::CfgIdxW-1:0]  cfg_idx,
    input  logic [afc_pkg::CfgDataW-1:0] cfg_data
);
    import afc_pkg::*;

    logic [63:0] key_reg [4];
    logic [2:0]  klen_reg;
    logic [63:0] ivh_reg, ivl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            klen_reg <= 3'd4;
            ivh_reg <= '0;
            ivl_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_idx))
                REG_KEY0:   key_reg[0] <= cfg_data;
                REG_KEY1:   key_reg[1] <= cfg_data;
                REG_KEY2:   key_reg[2] <= cfg_data;
                REG_KEY3:   key_reg[3] <= cfg_data;
                REG_KEYLEN: klen_reg <= cfg_data[2:0];
                REG_IV_HI:  ivh_reg <= cfg_data;
                REG_IV_LO:  ivl_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    state_t      state_reg, state_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic        sched_reg, sched_next;
    logic        dir_reg, dir_next;
    logic        rst_item_reg, rst_item_next;
    blk_t        in_reg, in_next;
    blk_t        chain_reg, chain_next;
    logic [63:0] a_reg, a_next, b_reg, b_next;
    blk_t        res_reg, res_next;
    logic [63:0] wk_reg [2];

    // key pair memory: even word and odd word per round
    logic [63:0] kev_mem [Rounds];
    logic [63:0] kod_mem [Rounds];
    logic [63:0] kev_q, kod_q;
    logic [RoundW-1:0] rd_addr;

    logic        seed, step;
    logic [63:0] gword, ra, rb;
    logic [RoundW-1:0] rnd;

    afc_keygen u_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .seed    (seed),
        .step    (step),
        .key0    (key_reg[0]),
        .key1    (key_reg[1]),
        .key2    (key_reg[2]),
        .key3    (key_reg[3]),
        .key_len (klen_reg),
        .word    (gword)
    );

    afc_round u_round (
        .decrypt (dir_reg),
        .a       (a_reg),
        .b       (b_reg),
        .k0      (kev_q),
        .k1      (kod_q),
        .a_out   (ra),
        .b_out   (rb)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXPAND && cnt_reg != 8'd0 && cnt_reg[0])
            kev_mem[cnt_reg[6:1]] <= gword;
        if (state_reg == ST_EXPAND && cnt_reg != 8'd0 && !cnt_reg[0])
            kod_mem[6'(cnt_reg[7:1] - 7'd1)] <= gword;
        kev_q <= kev_mem[rd_addr];
        kod_q <= kod_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WHITE)
            wk_reg[cnt_reg[0]] <= gword;
    end

    assign in_ch.ready = (state_reg == ST_IDLE) && !out_ch.valid;
    assign out_ch.valid = (state_reg == ST_DONE);
    assign out_ch.data = res_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        sched_next = sched_reg;
        dir_next = dir_reg;
        rst_item_next = rst_item_reg;
        in_next = in_reg;
        chain_next = chain_reg;
        a_next = a_reg;
        b_next = b_reg;
        res_next = res_reg;
        seed = 1'b0;
        step = 1'b0;
        rnd = dir_reg ? 6'(Rounds - 1 - int'(cnt_reg[5:0])) : cnt_reg[5:0];
        rd_addr = rnd;
        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = dir_reg ? 6'(Rounds - 1) : 6'd0;
                if (in_ch.valid && in_ch.ready)
                begin
                    dir_next = in_ch.data[129];
                    rst_item_next = in_ch.data[128];
                    in_next = in_ch.data[127:0];
                    cnt_next = '0;
                    if (in_ch.data[128] || !sched_reg)
                    begin
                        state_next = ST_EXPAND;
                        seed = 1'b1;
                    end
                    else
                        state_next = ST_LOAD;
                end
            end
            ST_EXPAND:
            begin
                // cnt 1..128 write keys; cnt 0 is the seeded cycle
                if (cnt_reg != 8'd0) step = 1'b1;
                if (cnt_reg == 8'(NumKeys))
                begin
                    state_next = ST_WHITE;
                    cnt_next = '0;
                end
                else
                    cnt_next = cnt_reg + 8'd1;
            end
            ST_WHITE:
            begin
                step = 1'b1;
                cnt_next = cnt_reg + 8'd1;
                if (cnt_reg[0])
                begin
                    state_next = ST_LOAD;
                    sched_next = 1'b1;
                    cnt_next = '0;
                end
            end
            ST_LOAD:
            begin
                rd_addr = dir_reg ? 6'(Rounds - 1) : 6'd0;
                if (rst_item_reg)
                    chain_next = {ivh_reg, ivl_reg};
                if (dir_reg)
                begin
                    a_next = in_reg.hi ^ wk_reg[0];
                    b_next = in_reg.lo ^ wk_reg[1];
                end
                else
                begin
                    a_next = in_reg.hi ^ (rst_item_reg ? ivh_reg : chain_reg.hi);
                    b_next = in_reg.lo ^ (rst_item_reg ? ivl_reg : chain_reg.lo);
                end
                cnt_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                rd_addr = dir_reg ? 6'(Rounds - 2 - int'(cnt_reg[5:0]))
                                  : 6'(cnt_reg[5:0] + 6'd1);
                a_next = ra;
                b_next = rb;
                cnt_next = cnt_reg + 8'd1;
                if (cnt_reg == 8'(Rounds - 1))
                begin
                    state_next = ST_DONE;
                    if (dir_reg)
                    begin
                        res_next = {ra ^ chain_reg.hi, rb ^ chain_reg.lo};
                        chain_next = in_reg;
                    end
                    else
                    begin
                        res_next = {ra ^ wk_reg[0], rb ^ wk_reg[1]};
                        chain_next = {ra ^ wk_reg[0], rb ^ wk_reg[1]};
                    end
                end
            end
            ST_DONE:
            begin
                if (out_ch.ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            sched_reg <= 1'b0;
            dir_reg <= 1'b0;
            rst_item_reg <= 1'b0;
            chain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            sched_reg <= sched_next;
            dir_reg <= dir_next;
            rst_item_reg <= rst_item_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg <= in_next;
        a_reg <= a_next;
        b_reg <= b_next;
        res_reg <= res_next;
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready)
        else $error("accept while busy");
    a_sched_after_expand: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> sched_reg)
        else $error("rounds without schedule");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(res_reg)))
        else $error("result dropped");
endmodule
